/* hdl/mts_pkg.sv */
package mts_pkg;

    localparam int TIMERS    = 16;
    localparam int TIME_BITS = 32;
    localparam int ID_BITS   = 16;
    localparam int SLOT_BITS = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CNT_BITS  = $clog2(TIMERS + 1);

    localparam int DELAY_BITS  = 31;
    localparam int PERIOD_BITS = 31;
    localparam int TID_BITS    = 16;
    localparam int STATUS_BITS = 3;
    localparam int RID_BITS    = 16;
    localparam int IN_BITS     = 80;
    localparam int OUT_BITS    = 24;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_CREATE  = 2'd1,
        OP_DESTROY = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_FIRED     = 3'd0,
        ST_CREATED   = 3'd1,
        ST_DESTROYED = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_PRESENT   = 3'd4,
        ST_ABSENT    = 3'd5,
        ST_FULL      = 3'd6
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input transaction, advance time on tick
        logic scan_clr;   // clear scan pointer and best/match search
        logic scan_step;  // examine one slot
        logic commit;     // apply the op's effect and build the result
        logic mark_fire;  // fire best candidate of this pass
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;  // last slot examined this cycle
        logic is_tick;
        logic found;      // tick: a candidate was seen this pass
        logic more;       // tick: another candidate remains after this one
    } dp_sts_t;

endpackage

/* hdl/multi_timer_scheduler.sv */
// multi_timer_scheduler: table of TIMERS software timers
// s_axis carries one operation per transaction: tick, create, destroy or query
// m_axis returns result transactions; tlast marks the final one of an operation
// create, destroy and query give exactly one result; a tick gives one result per
// due timer, oldest deadline first (ties to the lower slot), or none at all
// each operation scans the slot table, one slot per cycle, before its first result,
// and each further tick result costs another full scan, started once the previous
// one is taken, since the best due timer is searched anew
// one operation is in flight at a time; s_axis_tready is low until the last
// result is taken
// a stalled m_axis_tready holds the result and the scan; nothing is lost
// reset empties the table, sets time to zero and the next identifier to one
module multi_timer_scheduler
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // op[1:0], delay_ms[32:2], period_ms[63:33], timer_id[79:64]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // status[2:0], result_id[18:3], zero fill
    output logic        m_axis_tlast
);
    import mts_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    in_fire;
    logic [STATUS_BITS-1:0] status;
    logic [RID_BITS-1:0]    result_id;

    // input transaction accepted
    assign in_fire = s_axis_tvalid && s_axis_tready;

    mts_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_last  (m_axis_tlast),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    mts_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (s_axis_tdata[1:0]),
        .in_delay   (s_axis_tdata[32:2]),
        .in_period  (s_axis_tdata[63:33]),
        .in_tid     (s_axis_tdata[79:64]),
        .res_status (status),
        .res_id     (result_id)
    );

    // result packing, zero fill above result_id
    assign m_axis_tdata = {5'd0, result_id, status};

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= ST_FULL)
        else $error("bad status code");
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] == ST_FULL |-> m_axis_tdata[18:3] == 16'd0)
        else $error("full result carries an identifier");
`endif
endmodule

/* hdl/mts_datapath.sv */
module mts_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  mts_pkg::dp_cmd_t                  cmd,
    output mts_pkg::dp_sts_t                  sts,
    input  logic [1:0]                        in_op,
    input  logic [mts_pkg::DELAY_BITS-1:0]    in_delay,
    input  logic [mts_pkg::PERIOD_BITS-1:0]   in_period,
    input  logic [mts_pkg::TID_BITS-1:0]      in_tid,
    output logic [mts_pkg::STATUS_BITS-1:0]   res_status,
    output logic [mts_pkg::RID_BITS-1:0]      res_id
);
    import mts_pkg::*;

    logic [TIMERS-1:0]    valid_reg;
    logic [TIMERS-1:0]    fired_reg;
    logic [ID_BITS-1:0]   ident_mem [TIMERS];
    logic [TIME_BITS-1:0] dl_mem [TIMERS];
    logic [TIME_BITS-1:0] per_mem [TIMERS];
    logic [TIME_BITS-1:0] now_reg;
    logic [ID_BITS-1:0]   next_id_reg;
    logic [1:0]           op_reg;
    logic [TIME_BITS-1:0] delay_reg;
    logic [TIME_BITS-1:0] period_reg;
    logic [ID_BITS-1:0]   tid_reg;
    logic [SLOT_BITS-1:0] ptr_reg;
    logic                 hit_reg;       // tick: best candidate / others: match or free found
    logic                 more_reg;
    logic [SLOT_BITS-1:0] sel_reg;
    logic [TIME_BITS-1:0] best_age_reg;
    logic [STATUS_BITS-1:0] status_reg;
    logic [RID_BITS-1:0]  rid_reg;

    logic [TIME_BITS-1:0] diff;
    logic [TIME_BITS-1:0] age;
    logic                 due;
    logic                 cand;
    logic                 better;
    logic                 id_match;
    logic [ID_BITS-1:0]   id_inc;

    always_comb
    begin
        diff     = dl_mem[ptr_reg] - now_reg;
        age      = now_reg - dl_mem[ptr_reg];
        due      = (diff == '0) || diff[TIME_BITS-1];
        cand     = valid_reg[ptr_reg] && !fired_reg[ptr_reg] && due;
        better   = !hit_reg || (age > best_age_reg);
        id_match = valid_reg[ptr_reg] && (ident_mem[ptr_reg] == tid_reg);
        id_inc   = next_id_reg + ID_BITS'(1);
    end

    assign sts.scan_done = (ptr_reg == SLOT_BITS'(TIMERS - 1));
    assign sts.is_tick   = (op_reg == OP_TICK);
    assign sts.found     = hit_reg;
    assign sts.more      = more_reg;
    assign res_status    = status_reg;
    assign res_id        = rid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            fired_reg   <= '0;
            now_reg     <= '0;
            next_id_reg <= ID_BITS'(1);
        end
        else
        begin
            if (cmd.load)
            begin
                fired_reg <= '0;
                if (in_op == OP_TICK)
                begin
                    now_reg <= now_reg + TIME_BITS'(1);
                end
            end
            if (cmd.commit)
            begin
                unique case (op_t'(op_reg))
                    OP_TICK:
                    begin
                    end
                    OP_CREATE:
                    begin
                        if (hit_reg)
                        begin
                            valid_reg[sel_reg] <= 1'b1;
                            next_id_reg <= (id_inc == '0) ? ID_BITS'(1) : id_inc;
                        end
                    end
                    OP_DESTROY:
                    begin
                        if (hit_reg)
                        begin
                            valid_reg[sel_reg] <= 1'b0;
                        end
                    end
                    OP_QUERY:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.mark_fire)
            begin
                fired_reg[sel_reg] <= 1'b1;
                if (per_mem[sel_reg] == '0)
                begin
                    valid_reg[sel_reg] <= 1'b0;
                end
            end
        end
    end

    // payload, search state, timer memories and result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_op;
            delay_reg  <= TIME_BITS'(in_delay);
            period_reg <= TIME_BITS'(in_period);
            tid_reg    <= ID_BITS'(in_tid);
        end
        if (cmd.scan_clr)
        begin
            ptr_reg  <= '0;
            hit_reg  <= 1'b0;
            more_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            ptr_reg <= ptr_reg + SLOT_BITS'(1);
            unique case (op_t'(op_reg))
                OP_TICK:
                begin
                    if (cand)
                    begin
                        if (hit_reg)
                        begin
                            more_reg <= 1'b1;
                        end
                        if (better)
                        begin
                            hit_reg      <= 1'b1;
                            sel_reg      <= ptr_reg;
                            best_age_reg <= age;
                        end
                    end
                end
                OP_CREATE:
                begin
                    if (!hit_reg && !valid_reg[ptr_reg])
                    begin
                        hit_reg <= 1'b1;
                        sel_reg <= ptr_reg;
                    end
                end
                OP_DESTROY, OP_QUERY:
                begin
                    if (!hit_reg && id_match)
                    begin
                        hit_reg <= 1'b1;
                        sel_reg <= ptr_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.commit)
        begin
            unique case (op_t'(op_reg))
                OP_TICK:
                begin
                end
                OP_CREATE:
                begin
                    if (hit_reg)
                    begin
                        ident_mem[sel_reg] <= next_id_reg;
                        dl_mem[sel_reg]    <= now_reg + delay_reg;
                        per_mem[sel_reg]   <= period_reg;
                        status_reg         <= ST_CREATED;
                        rid_reg            <= RID_BITS'(next_id_reg);
                    end
                    else
                    begin
                        status_reg <= ST_FULL;
                        rid_reg    <= '0;
                    end
                end
                OP_DESTROY:
                begin
                    status_reg <= hit_reg ? ST_DESTROYED : ST_NOT_FOUND;
                    rid_reg    <= RID_BITS'(tid_reg);
                end
                OP_QUERY:
                begin
                    status_reg <= hit_reg ? ST_PRESENT : ST_ABSENT;
                    rid_reg    <= RID_BITS'(tid_reg);
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.mark_fire)
        begin
            status_reg <= ST_FIRED;
            rid_reg    <= RID_BITS'(ident_mem[sel_reg]);
            if (per_mem[sel_reg] != '0)
            begin
                dl_mem[sel_reg] <= dl_mem[sel_reg] + per_mem[sel_reg];
            end
        end
    end

`ifndef SYNTHESIS
    // a fired timer is never a candidate again in the same tick
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step && fired_reg[ptr_reg] |-> !cand)
        else $error("fired slot reconsidered");
    // identifier counter never holds zero
    assert property (@(posedge clk) disable iff (!rst_n)
        next_id_reg != '0)
        else $error("next identifier is zero");
    // firing only on a found candidate
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mark_fire |-> hit_reg && valid_reg[sel_reg])
        else $error("fire without candidate");
`endif
endmodule

/* hdl/mts_ctrl.sv */
module mts_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    output logic             in_ready,
    output logic             out_valid,
    output logic             out_last,
    input  logic             out_ready,
    output mts_pkg::dp_cmd_t cmd,
    input  mts_pkg::dp_sts_t sts
);
    import mts_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_OUT    = 5'b01000,
        S_WAIT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   more_reg, more_next;   // result in output is not the last

    always_comb
    begin
        state_next = state_reg;
        more_next  = more_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        out_last   = !more_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load     = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.is_tick)
                begin
                    if (sts.found)
                    begin
                        cmd.mark_fire = 1'b1;
                        more_next     = sts.more;
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.commit = 1'b1;
                    more_next  = 1'b0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (more_reg)
                    begin
                        cmd.scan_clr = 1'b1;
                        state_next   = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_WAIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            more_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            more_reg  <= more_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("input taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
`endif
endmodule

/* bench/tb_multi_timer_scheduler.sv */
module tb_multi_timer_scheduler;
    import mts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 80;

    // result transaction as seen on m_axis
    typedef struct packed {
        status_t          status;
        logic [15:0]      rid;
        logic             last;
    } timer_event_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    multi_timer_scheduler uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // shadow timer table kept by the predictor
    logic                 tbl_valid    [TIMERS];
    logic [ID_BITS-1:0]   tbl_ident    [TIMERS];
    logic [TIME_BITS-1:0] tbl_deadline [TIMERS];
    logic [TIME_BITS-1:0] tbl_period   [TIMERS];
    logic [TIME_BITS-1:0] clock_ms;
    logic [ID_BITS-1:0]   ident_next;

    timer_event_t pending_events[$];
    int           error_count;
    int           idle_cycles;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           result_count;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    // one expected result transaction, pushed in order
    task automatic push_event(input status_t st, input logic [15:0] id);
        timer_event_t ev;
        ev.status = st;
        ev.rid    = id;
        ev.last   = 1'b0;
        pending_events.push_back(ev);
    endtask

    function automatic logic is_due(input logic [TIME_BITS-1:0] dl);
        logic [TIME_BITS-1:0] d;
        d = dl - clock_ms;
        return (d == '0) || d[TIME_BITS-1];
    endfunction

    function automatic int lookup_slot(input logic [ID_BITS-1:0] id);
        for (int i = 0; i < TIMERS; i++)
            if (tbl_valid[i] && tbl_ident[i] == id)
                return i;
        return -1;
    endfunction

    // predict the result transactions of one operation
    task automatic predict_timers(input op_t op, input logic [30:0] dly,
                                  input logic [30:0] per, input logic [15:0] tid);
        logic [TIMERS-1:0]    due;
        logic [TIME_BITS-1:0] age;
        logic [TIME_BITS-1:0] best_age;
        int                   best;
        int                   slot;
        int                   n;
        n = 0;
        case (op)
            OP_TICK:
            begin
                clock_ms = clock_ms + 1;
                due = '0;
                for (int i = 0; i < TIMERS; i++)
                    due[i] = tbl_valid[i] && is_due(tbl_deadline[i]);
                while (due != '0)
                begin
                    best = -1;
                    best_age = '0;
                    for (int i = 0; i < TIMERS; i++)
                    begin
                        age = clock_ms - tbl_deadline[i];
                        if (due[i] && (best < 0 || age > best_age))
                        begin
                            best = i;
                            best_age = age;
                        end
                    end
                    due[best] = 1'b0;
                    push_event(ST_FIRED, tbl_ident[best]);
                    n++;
                    if (tbl_period[best] != '0)
                        tbl_deadline[best] = tbl_deadline[best] + tbl_period[best];
                    else
                        tbl_valid[best] = 1'b0;
                end
            end
            OP_CREATE:
            begin
                slot = -1;
                for (int i = TIMERS - 1; i >= 0; i--)
                    if (!tbl_valid[i])
                        slot = i;
                if (slot < 0)
                    push_event(ST_FULL, '0);
                else
                begin
                    tbl_valid[slot]    = 1'b1;
                    tbl_ident[slot]    = ident_next;
                    tbl_deadline[slot] = clock_ms + TIME_BITS'(dly);
                    tbl_period[slot]   = TIME_BITS'(per);
                    push_event(ST_CREATED, ident_next);
                    ident_next = ident_next + 1;
                    if (ident_next == '0)
                        ident_next = 1;
                end
                n = 1;
            end
            OP_DESTROY:
            begin
                slot = lookup_slot(tid);
                if (slot >= 0)
                begin
                    tbl_valid[slot] = 1'b0;
                    push_event(ST_DESTROYED, tid);
                end
                else
                    push_event(ST_NOT_FOUND, tid);
                n = 1;
            end
            default:
            begin
                push_event(lookup_slot(tid) >= 0 ? ST_PRESENT : ST_ABSENT, tid);
                n = 1;
            end
        endcase
        if (n > 0)
            pending_events[pending_events.size() - 1].last = 1'b1;
    endtask

    // send one operation transaction, then predict its results
    task automatic send_op(input op_t op, input logic [30:0] dly = '0,
                           input logic [30:0] per = '0, input logic [15:0] tid = '0);
        @(posedge clk);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tid, per, dly, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_timers(op, dly, per, tid);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random backpressure on m_axis
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // checker: compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        timer_event_t exp_ev;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            result_count++;
            if (pending_events.size() == 0)
                report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
            else
            begin
                exp_ev = pending_events.pop_front();
                if (m_axis_tdata[2:0] !== exp_ev.status)
                    report_mismatch($sformatf("status %0d expected %0d",
                                              m_axis_tdata[2:0], exp_ev.status));
                if (m_axis_tdata[18:3] !== exp_ev.rid)
                    report_mismatch($sformatf("id %0d expected %0d",
                                              m_axis_tdata[18:3], exp_ev.rid));
                if (m_axis_tlast !== exp_ev.last)
                    report_mismatch($sformatf("tlast %b expected %b",
                                              m_axis_tlast, exp_ev.last));
            end
        end
    end

    // watchdog: cycles without any accepted transaction
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // directed: every op, extreme fields, full table, ties, late fire order
    task automatic test_directed();
        send_op(OP_TICK);                                   // nothing due
        send_op(OP_QUERY, '0, '0, 16'd0);                   // absent
        send_op(OP_DESTROY, '1, '1, 16'hFFFF);              // not found
        send_op(OP_CREATE, 31'd0, 31'd0);                   // due on next tick
        send_op(OP_CREATE, 31'd2, 31'd1);                   // periodic
        send_op(OP_CREATE, 31'd2, 31'd0);                   // ties with slot 1
        send_op(OP_CREATE, 31'h7FFFFFFF, 31'h7FFFFFFF);     // far deadline
        send_op(OP_QUERY, '0, '0, 16'd4);
        repeat (3) send_op(OP_TICK);
        send_op(OP_DESTROY, '0, '0, 16'd2);
        send_op(OP_DESTROY, '0, '0, 16'd2);
        // fill the table past its end
        for (int i = 0; i < TIMERS + 1; i++)
            send_op(OP_CREATE, 31'($urandom_range(5)), 31'($urandom_range(1)));
        repeat (4) send_op(OP_TICK);
        wait_drained();
    endtask

    // random: mostly short timers with ticks, some noise ids
    task automatic test_random(input int count);
        logic [30:0] dly;
        logic [30:0] per;
        logic [15:0] tid;
        int          r;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(99);
            dly = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(6));
            per = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(4));
            tid = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 24));
            if (r < 45)
                send_op(OP_TICK);
            else if (r < 70)
                send_op(OP_CREATE, dly, per, 16'($urandom));
            else if (r < 85)
                send_op(OP_DESTROY, dly, per, tid);
            else
                send_op(OP_QUERY, dly, per, tid);
        end
        wait_drained();
    endtask

    // empty the table, then create and fire one-shot timers in turn
    task automatic test_ident_wrap();
        for (int i = 0; i < TIMERS; i++)
            if (tbl_valid[i])
                send_op(OP_DESTROY, '0, '0, tbl_ident[i]);
        for (int i = 0; i < 8; i++)
        begin
            send_op(OP_CREATE, 31'd0, 31'd0);
            send_op(OP_TICK);
        end
        send_op(OP_CREATE, 31'd1, 31'd0);
        send_op(OP_QUERY, '0, '0, ident_next - 16'd1);
        wait_drained();
    endtask

    initial
    begin
        error_count   = 0;
        idle_cycles   = 0;
        result_count  = 0;
        send_idle_pct = 22;
        recv_idle_pct = 75;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        for (int i = 0; i < TIMERS; i++)
        begin
            tbl_valid[i]    = 1'b0;
            tbl_ident[i]    = '0;
            tbl_deadline[i] = '0;
            tbl_period[i]   = '0;
        end
        clock_ms   = '0;
        ident_next = 1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(40);
        send_idle_pct = 75;
        recv_idle_pct = 22;
        test_random(40);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(40);
        test_ident_wrap();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_events.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/mts_pkg.sv
hdl/mts_datapath.sv
hdl/mts_ctrl.sv
hdl/multi_timer_scheduler.sv
bench/tb_multi_timer_scheduler.sv
